FILE: sv/rit_pkg.sv
// ----------------------------------------------------------------------------
// rit_pkg: shared types and constants of the radix text unit
// Widths, register indexes, character codes and the command and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package rit_pkg;

  // largest radix and the widths that follow from it
  localparam int MAX_BASE  = 16;
  localparam int DIGIT_W   = $clog2(MAX_BASE);
  localparam int RADIX_W   = DIGIT_W + 1;

  // number and character widths
  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int SYM_W     = 64;
  localparam int SYMS_PER_WORD = SYM_W / CHAR_W;

  // digit stack: a 32-bit magnitude has at most 32 digits in radix 2
  localparam int MAX_DIGITS = VALUE_W;
  localparam int PTR_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = PTR_W + 1;

  // division slice: quotient bits resolved per cycle
  localparam int SLICE_W     = 8;
  localparam int SLICES      = VALUE_W / SLICE_W;
  localparam int SLICE_CNT_W = $clog2(SLICES);

  // configuration channel
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] MINUS_CH = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CH  = 8'h2B;
  localparam logic [CHAR_W-1:0] NUL_CH   = 8'h00;

  // which result the datapath puts on the output
  typedef enum logic [1:0] {
    SEL_ERROR,
    SEL_MINUS,
    SEL_DIGIT
  } out_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;      // capture a new value
    logic     div_step;  // run one division slice
    logic     pop;       // drop the digit just delivered
    out_sel_t out_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic base_ok;     // configured base passes validation
    logic neg;         // captured value is negative
    logic slice_last;  // current slice finishes a digit
    logic quot_zero;   // quotient after this slice is zero
    logic cnt_one;     // one digit left on the stack
  } dp_status_t;

endpackage

FILE: sv/rit_if.sv
// ----------------------------------------------------------------------------
// rit_if: handshake channels of the radix text unit
// Input value channel, output character channel and configuration write
// channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface rit_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [rit_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rit_out_if;
  logic                        valid;
  logic                        ready;
  logic [rit_pkg::CHAR_W-1:0]  out_char;
  logic                        last;
  logic                        base_invalid;

  modport source (output valid, output out_char, output last, output base_invalid,
                  input ready);
  modport sink   (input valid, input out_char, input last, input base_invalid,
                  output ready);
endinterface

interface rit_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rit_pkg::CFG_IDX_W-1:0]   index;
  logic [rit_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/rit_datapath.sv
// ----------------------------------------------------------------------------
// rit_datapath: registers, base check, divider slice and digit stack
// Holds the configuration, validates the base, divides the magnitude by the
// radix eight quotient bits per cycle and stacks the remainders.
// ----------------------------------------------------------------------------
module rit_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rit_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rit_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [rit_pkg::VALUE_W-1:0] value,
  input  rit_pkg::dp_cmd_t                 cmd,
  output rit_pkg::dp_status_t              status,
  output logic [rit_pkg::CHAR_W-1:0]       out_char,
  output logic                             last,
  output logic                             base_invalid
);

  // configuration
  logic [rit_pkg::RADIX_W-1:0] base_length;
  logic [rit_pkg::SYM_W-1:0]   symbols_low;
  logic [rit_pkg::SYM_W-1:0]   symbols_high;
  logic                        base_ok;

  logic [rit_pkg::CHAR_W-1:0]  sym [rit_pkg::MAX_BASE];
  logic [rit_pkg::MAX_BASE-1:0] active;
  logic                        base_ok_next;

  // conversion
  logic [rit_pkg::VALUE_W-1:0]     mag;
  logic [rit_pkg::VALUE_W-1:0]     mag_next;
  logic                            neg;
  logic [rit_pkg::DIGIT_W-1:0]     rem;
  logic [rit_pkg::SLICE_CNT_W-1:0] slice;
  logic [rit_pkg::CNT_W-1:0]       cnt;
  logic [rit_pkg::DIGIT_W-1:0]     stack [rit_pkg::MAX_DIGITS];

  logic [rit_pkg::DIGIT_W:0]       trial     [rit_pkg::SLICE_W];
  logic [rit_pkg::DIGIT_W-1:0]     rem_chain [rit_pkg::SLICE_W+1];
  logic [rit_pkg::SLICE_W-1:0]     qbits;
  logic [rit_pkg::PTR_W-1:0]       rd_idx;
  logic [rit_pkg::DIGIT_W-1:0]     rd_digit;

  // symbol table view of the two symbol words
  always_comb begin
    for (int i = 0; i < rit_pkg::MAX_BASE; i++) begin
      if (i < rit_pkg::SYMS_PER_WORD) begin
        sym[i] = symbols_low[i*rit_pkg::CHAR_W +: rit_pkg::CHAR_W];
      end else begin
        sym[i] = symbols_high[(i-rit_pkg::SYMS_PER_WORD)*rit_pkg::CHAR_W +: rit_pkg::CHAR_W];
      end
    end
  end

  // base check: length in range, no forbidden symbol, no duplicate
  always_comb begin
    base_ok_next = (base_length >= rit_pkg::RADIX_W'(2)) &&
                   (base_length <= rit_pkg::RADIX_W'(rit_pkg::MAX_BASE));
    for (int i = 0; i < rit_pkg::MAX_BASE; i++) begin
      active[i] = rit_pkg::RADIX_W'(i) < base_length;
    end
    for (int i = 0; i < rit_pkg::MAX_BASE; i++) begin
      if (active[i] && (sym[i] == rit_pkg::NUL_CH || sym[i] == rit_pkg::PLUS_CH ||
                        sym[i] == rit_pkg::MINUS_CH)) begin
        base_ok_next = 1'b0;
      end
      for (int j = i + 1; j < rit_pkg::MAX_BASE; j++) begin
        if (active[j] && sym[i] == sym[j]) begin
          base_ok_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
      base_ok      <= 1'b0;
    end else begin
      base_ok <= base_ok_next;
      if (cfg_we) begin
        unique case (cfg_index)
          rit_pkg::REG_BASE_LENGTH:  base_length  <= cfg_data[rit_pkg::RADIX_W-1:0];
          rit_pkg::REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
          rit_pkg::REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // restoring division slice, msb first
  always_comb begin
    rem_chain[0] = rem;
    for (int i = 0; i < rit_pkg::SLICE_W; i++) begin
      trial[i] = {rem_chain[i], mag[rit_pkg::VALUE_W-1-i]};
      if (trial[i] >= base_length) begin
        qbits[rit_pkg::SLICE_W-1-i] = 1'b1;
        rem_chain[i+1] = rit_pkg::DIGIT_W'(trial[i] - base_length);
      end else begin
        qbits[rit_pkg::SLICE_W-1-i] = 1'b0;
        rem_chain[i+1] = trial[i][rit_pkg::DIGIT_W-1:0];
      end
    end
    mag_next = {mag[rit_pkg::VALUE_W-rit_pkg::SLICE_W-1:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice <= '0;
      cnt   <= '0;
    end else if (cmd.load) begin
      slice <= '0;
      cnt   <= '0;
    end else if (cmd.div_step) begin
      slice <= slice + 1'b1;
      if (slice == rit_pkg::SLICE_CNT_W'(rit_pkg::SLICES - 1)) begin
        cnt <= cnt + 1'b1;
      end
    end else if (cmd.pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[rit_pkg::VALUE_W-1];
      mag <= value[rit_pkg::VALUE_W-1] ? (rit_pkg::VALUE_W'(0) - rit_pkg::VALUE_W'(value))
                                       : rit_pkg::VALUE_W'(value);
      rem <= '0;
    end else if (cmd.div_step) begin
      mag <= mag_next;
      if (slice == rit_pkg::SLICE_CNT_W'(rit_pkg::SLICES - 1)) begin
        stack[cnt[rit_pkg::PTR_W-1:0]] <= rem_chain[rit_pkg::SLICE_W];
        rem <= '0;
      end else begin
        rem <= rem_chain[rit_pkg::SLICE_W];
      end
    end
  end

  // top of stack: count minus one, wraps to the last entry when full
  assign rd_idx   = cnt[rit_pkg::PTR_W-1:0] - 1'b1;
  assign rd_digit = stack[rd_idx];

  assign status.base_ok    = base_ok;
  assign status.neg        = neg;
  assign status.slice_last = (slice == rit_pkg::SLICE_CNT_W'(rit_pkg::SLICES - 1));
  assign status.quot_zero  = (mag_next == '0);
  assign status.cnt_one    = (cnt == rit_pkg::CNT_W'(1));

  always_comb begin
    unique case (cmd.out_sel)
      rit_pkg::SEL_ERROR: begin
        out_char     = rit_pkg::NUL_CH;
        last         = 1'b1;
        base_invalid = 1'b1;
      end
      rit_pkg::SEL_MINUS: begin
        out_char     = rit_pkg::MINUS_CH;
        last         = 1'b0;
        base_invalid = 1'b0;
      end
      default: begin
        out_char     = sym[rd_digit];
        last         = (cnt == rit_pkg::CNT_W'(1));
        base_invalid = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/rit_controller.sv
// ----------------------------------------------------------------------------
// rit_controller: sequencing of one conversion
// Accepts a value, checks the base, runs the divider digit by digit, then
// delivers the sign and the digits most significant first, or one error character.
// ----------------------------------------------------------------------------
module rit_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rit_pkg::dp_status_t status,
  output rit_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT,
    ST_ERROR
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.base_ok ? ST_DIV : ST_ERROR;
      end
      ST_DIV: begin
        if (status.slice_last && status.quot_zero) begin
          state_next = status.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_ready) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_ready && status.cnt_one) state_next = ST_IDLE;
      end
      ST_ERROR: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load     = in_ready && in_valid;
    cmd.div_step = (state == ST_DIV);
    cmd.pop      = (state == ST_DIGIT) && out_ready;
    unique case (state)
      ST_ERROR: cmd.out_sel = rit_pkg::SEL_ERROR;
      ST_SIGN:  cmd.out_sel = rit_pkg::SEL_MINUS;
      default:  cmd.out_sel = rit_pkg::SEL_DIGIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == ST_IDLE);
      out_valid <= (state_next == ST_SIGN) || (state_next == ST_DIGIT) ||
                   (state_next == ST_ERROR);
    end
  end

endmodule

FILE: sv/signed_integer_to_radix_text_unit.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_unit: signed value to radix text
// Writes a signed 32-bit value as text in a configurable radix of up to 16
// symbols, one character per beat, sign first, most significant digit first.
//
//   channel  role   fields                         beat
//   items    sink   value[31:0] signed             one value
//   chars    source out_char[7:0] last base_invalid one character
//   cfg      sink   index[1:0] data[63:0]          one register write
//
// one value at a time: accept, read the base check, divide digit by digit in
// the divider (8 quotient bits per cycle over 32 bits), then deliver the
// characters
// reset is synchronous; it clears the configuration registers to zero, so the
// base reads invalid until configured; no clearing pass
// a stall on chars holds the current character; items is not taken again
// until the last character of the value has been delivered
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_unit (
  input  logic           clk,
  input  logic           rst,
  rit_in_if.sink         items,
  rit_out_if.source      chars,
  rit_cfg_if.sink        cfg
);

  rit_pkg::dp_cmd_t    cmd;
  rit_pkg::dp_status_t status;

  // register writes are always taken; the user must send them only while idle, the block does not enforce it
  assign cfg.ready = 1'b1;

  // sequencer: accept, check, divide, deliver
  rit_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // configuration, base check, divider slice, digit stack, output select
  rit_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg.valid && cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .value        (items.value),
    .cmd          (cmd),
    .status       (status),
    .out_char     (chars.out_char),
    .last         (chars.last),
    .base_invalid (chars.base_invalid)
  );

  // no new value while a character is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && chars.valid))
    else $error("input ready while a character is pending");

  // a taken value blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> !items.ready)
    else $error("input still ready after a value was taken");

  // the error result is always marked last
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.base_invalid |-> chars.last)
    else $error("base error without last");

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.out_char == rit_pkg::MINUS_CH |-> !chars.last)
    else $error("minus sign marked last");

endmodule
